FILE: rtl/lis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_pkg
// Shared types, widths, register indexes and datapath step codes for the
// line inlier scoring block.
// ----------------------------------------------------------------------------
package lis_pkg;

  localparam int COORD_W     = 16;
  localparam int LIMIT_W     = 12;
  localparam int LIM2_W      = 2 * LIMIT_W;
  localparam int CNT_W       = 13;
  localparam int DIST_W      = 34;
  localparam int ERR_W       = 36;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;

  localparam int COORD_BITS_DEFAULT = 16;
  localparam int MAX_POINTS         = 4096;
  localparam int COUNT_CAP_INT      = (MAX_POINTS < 8191) ? MAX_POINTS : 8191;
  localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(COUNT_CAP_INT);

  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [ERR_W-1:0]  ERR_MAX  = '1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd240;
  localparam logic [CNT_W-1:0]   MIN_RESET   = 13'd30;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_X    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Y    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Z    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_X    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_Y    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_Z    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INLIER_LIMIT = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INLIERS  = 4'd7;

  // multiplier steps, one product per step
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] ST_C0_POS = 5'd0;
  localparam logic [STEP_W-1:0] ST_C0_NEG = 5'd1;
  localparam logic [STEP_W-1:0] ST_C1_POS = 5'd2;
  localparam logic [STEP_W-1:0] ST_C1_NEG = 5'd3;
  localparam logic [STEP_W-1:0] ST_C2_POS = 5'd4;
  localparam logic [STEP_W-1:0] ST_C2_NEG = 5'd5;
  localparam logic [STEP_W-1:0] ST_V0     = 5'd6;
  localparam logic [STEP_W-1:0] ST_V1     = 5'd7;
  localparam logic [STEP_W-1:0] ST_V2     = 5'd8;
  localparam logic [STEP_W-1:0] ST_LIM    = 5'd9;
  localparam logic [STEP_W-1:0] ST_C0_HH  = 5'd10;
  localparam logic [STEP_W-1:0] ST_C0_HL  = 5'd11;
  localparam logic [STEP_W-1:0] ST_C0_LL  = 5'd12;
  localparam logic [STEP_W-1:0] ST_C1_HH  = 5'd13;
  localparam logic [STEP_W-1:0] ST_C1_HL  = 5'd14;
  localparam logic [STEP_W-1:0] ST_C1_LL  = 5'd15;
  localparam logic [STEP_W-1:0] ST_C2_HH  = 5'd16;
  localparam logic [STEP_W-1:0] ST_C2_HL  = 5'd17;
  localparam logic [STEP_W-1:0] ST_C2_LL  = 5'd18;
  localparam logic [STEP_W-1:0] ST_LAST   = ST_C2_LL;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      last_point;
  } in_item_t;

  typedef struct packed {
    logic              is_inlier;
    logic [DIST_W-1:0] dist_sq;
    logic [CNT_W-1:0]  inlier_count;
    logic [ERR_W-1:0]  error_total;
    logic              line_accepted;
    logic              pass_done;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_req_t;

  typedef struct packed {
    logic              load;
    logic              mul;
    logic [STEP_W-1:0] step;
    logic              div_init;
    logic              div_step;
    logic              finish;
  } cmd_t;

endpackage

FILE: rtl/lis_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_chan_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface lis_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ransac_line_inlier_scoring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ransac_line_inlier_scoring
// Scores hit points against one 3D line hypothesis.
// ----------------------------------------------------------------------------
// usage:
//   cfg_i  writes registers 0..7 (anchor xyz, second xyz, inlier limit,
//          min inliers); always ready, write only while the block is idle
//   in_i   one request per hit point; last_point closes the pass
//   out_o  one result per request: distance, inlier flag, running totals,
//          and on the last point the accept decision
// a request runs 19 steps of the shared multiplier, the drain and
//   divider-init states and the two-bit-per-cycle divider, then moves
//   into the output register
// a new request is taken while the previous result still sits in the
//   output register
// reset: registers return to zero anchors, limit 240, min inliers 30, and
//   the running totals clear
// stall: a held result keeps the next one waiting in the datapath, and no
//   new request is taken until that result moves into the output register
// ----------------------------------------------------------------------------
module ransac_line_inlier_scoring #(
  parameter int COORD_BITS = lis_pkg::COORD_BITS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lis_chan_if.sink   cfg_i,
  lis_chan_if.sink   in_i,
  lis_chan_if.source out_o
);

  lis_pkg::cmd_t      cmd;
  lis_pkg::out_item_t res;
  logic               in_ready;
  logic               out_valid;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = res;

  lis_ctrl #(
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  lis_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_req_i  (cfg_i.data),
    .in_item_i  (in_i.data),
    .cmd_i      (cmd),
    .out_item_o (res)
  );

  // one point in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request accepted while another is in flight");

  a_accept_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.line_accepted) |-> out_o.data.pass_done)
    else $error("line accepted outside the last point");

  a_inlier_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.is_inlier) |-> (out_o.data.inlier_count != '0))
    else $error("inlier with zero count");

  a_inlier_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.is_inlier) |-> (out_o.data.dist_sq < 34'h1000000))
    else $error("inlier distance above any threshold");

endmodule

FILE: rtl/lis_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_ctrl
// Sequencer: accepts one request, steps the shared multiplier, runs the
// radix-4 divider, then hands the result to the output register.
// ----------------------------------------------------------------------------
module lis_ctrl #(
  parameter int COORD_BITS = lis_pkg::COORD_BITS_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output lis_pkg::cmd_t cmd_o
);

  localparam int DIV_ITERS = 2 * COORD_BITS + 2;
  localparam int DCNT_W    = $clog2(DIV_ITERS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DINIT = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic [lis_pkg::STEP_W-1:0]  step_q, step_d;
  logic [DCNT_W-1:0]           dcnt_q, dcnt_d;
  logic                        ovalid_q, ovalid_d;
  logic                        out_free;

  assign out_free    = !ovalid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    dcnt_d   = dcnt_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o    = '0;
    cmd_o.step = step_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        if (step_q == lis_pkg::ST_LAST) begin
          state_d = S_DRAIN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_DRAIN: begin
        state_d = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        dcnt_d  = DCNT_W'(DIV_ITERS - 1);
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (dcnt_q == '0) begin
          state_d = S_DONE;
        end else begin
          dcnt_d = dcnt_q - 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          ovalid_d     = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= '0;
      dcnt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      dcnt_q   <= dcnt_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

FILE: rtl/lis_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_datapath
// Configuration registers, shared signed multiplier with accumulators,
// two-bit-per-cycle restoring divider, running totals and result register.
// ----------------------------------------------------------------------------
module lis_datapath #(
  parameter int COORD_BITS = lis_pkg::COORD_BITS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  lis_pkg::cfg_req_t  cfg_req_i,
  input  lis_pkg::in_item_t  in_item_i,
  input  lis_pkg::cmd_t      cmd_i,
  output lis_pkg::out_item_t out_item_o
);

  localparam int CB   = COORD_BITS;
  localparam int EW   = (CB > lis_pkg::COORD_W) ? CB : lis_pkg::COORD_W;
  localparam int XW   = CB + 1;          // coordinate differences
  localparam int MW   = CB + 2;          // multiplier operands
  localparam int PW   = 2 * MW;          // product
  localparam int CW   = 2 * CB + 2;      // cross components, signed
  localparam int MAGW = CW - 1;          // cross magnitude
  localparam int K    = CB + 1;          // split point of the magnitude
  localparam int SW   = 4 * CB + 4;      // squared cross norm
  localparam int DW   = 2 * CB + 2;      // squared direction norm
  localparam int DL   = lis_pkg::DIST_W;

  function automatic logic signed [XW-1:0] sx(input logic [lis_pkg::COORD_W-1:0] r);
    logic [EW-1:0] e;
    begin
      e  = EW'(r);
      sx = $signed({e[CB-1], e[CB-1:0]});
    end
  endfunction

  // configuration
  logic [lis_pkg::COORD_W-1:0] point_q [6];
  logic [lis_pkg::LIMIT_W-1:0] limit_q;
  logic [lis_pkg::CNT_W-1:0]   min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) begin
        point_q[k] <= '0;
      end
      limit_q <= lis_pkg::LIMIT_RESET;
      min_q   <= lis_pkg::MIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_req_i.index)
        lis_pkg::REG_ANCHOR_X:     point_q[0] <= cfg_req_i.value;
        lis_pkg::REG_ANCHOR_Y:     point_q[1] <= cfg_req_i.value;
        lis_pkg::REG_ANCHOR_Z:     point_q[2] <= cfg_req_i.value;
        lis_pkg::REG_SECOND_X:     point_q[3] <= cfg_req_i.value;
        lis_pkg::REG_SECOND_Y:     point_q[4] <= cfg_req_i.value;
        lis_pkg::REG_SECOND_Z:     point_q[5] <= cfg_req_i.value;
        lis_pkg::REG_INLIER_LIMIT: limit_q <= cfg_req_i.value[lis_pkg::LIMIT_W-1:0];
        lis_pkg::REG_MIN_INLIERS:  min_q   <= cfg_req_i.value[lis_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // line direction follows the point registers
  logic signed [XW-1:0] v [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      v[k] = sx(point_q[3+k]) - sx(point_q[k]);
    end
  end

  // point offsets and pass marker
  logic signed [XW-1:0] w_q [3];
  logic                 last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q[0] <= sx(point_q[0]) - sx(in_item_i.pos_x);
      w_q[1] <= sx(point_q[1]) - sx(in_item_i.pos_y);
      w_q[2] <= sx(point_q[2]) - sx(in_item_i.pos_z);
      last_q <= in_item_i.last_point;
    end
  end

  // cross product magnitudes split in two halves
  logic signed [CW-1:0] c_q [3];
  logic [MAGW-1:0]      m [3];
  logic [MAGW-K-1:0]    h [3];
  logic [K-1:0]         l [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m[k] = c_q[k][CW-1] ? MAGW'(-c_q[k]) : MAGW'(c_q[k]);
      h[k] = m[k][MAGW-1:K];
      l[k] = m[k][K-1:0];
    end
  end

  // shared multiplier
  logic signed [MW-1:0] a_op, b_op;
  logic signed [PW-1:0] p_d, p_q;
  logic [PW-1:0]        pu;
  logic [lis_pkg::STEP_W-1:0] pstep_q;
  logic                 pvalid_q;

  always_comb begin
    a_op = '0;
    b_op = '0;
    unique case (cmd_i.step)
      lis_pkg::ST_C0_POS: begin a_op = MW'(v[1]); b_op = MW'(w_q[2]); end
      lis_pkg::ST_C0_NEG: begin a_op = MW'(v[2]); b_op = MW'(w_q[1]); end
      lis_pkg::ST_C1_POS: begin a_op = MW'(v[2]); b_op = MW'(w_q[0]); end
      lis_pkg::ST_C1_NEG: begin a_op = MW'(v[0]); b_op = MW'(w_q[2]); end
      lis_pkg::ST_C2_POS: begin a_op = MW'(v[0]); b_op = MW'(w_q[1]); end
      lis_pkg::ST_C2_NEG: begin a_op = MW'(v[1]); b_op = MW'(w_q[0]); end
      lis_pkg::ST_V0:     begin a_op = MW'(v[0]); b_op = MW'(v[0]); end
      lis_pkg::ST_V1:     begin a_op = MW'(v[1]); b_op = MW'(v[1]); end
      lis_pkg::ST_V2:     begin a_op = MW'(v[2]); b_op = MW'(v[2]); end
      lis_pkg::ST_LIM: begin
        a_op = $signed(MW'(limit_q));
        b_op = $signed(MW'(limit_q));
      end
      lis_pkg::ST_C0_HH: begin a_op = $signed(MW'(h[0])); b_op = $signed(MW'(h[0])); end
      lis_pkg::ST_C0_HL: begin a_op = $signed(MW'(h[0])); b_op = $signed(MW'(l[0])); end
      lis_pkg::ST_C0_LL: begin a_op = $signed(MW'(l[0])); b_op = $signed(MW'(l[0])); end
      lis_pkg::ST_C1_HH: begin a_op = $signed(MW'(h[1])); b_op = $signed(MW'(h[1])); end
      lis_pkg::ST_C1_HL: begin a_op = $signed(MW'(h[1])); b_op = $signed(MW'(l[1])); end
      lis_pkg::ST_C1_LL: begin a_op = $signed(MW'(l[1])); b_op = $signed(MW'(l[1])); end
      lis_pkg::ST_C2_HH: begin a_op = $signed(MW'(h[2])); b_op = $signed(MW'(h[2])); end
      lis_pkg::ST_C2_HL: begin a_op = $signed(MW'(h[2])); b_op = $signed(MW'(l[2])); end
      lis_pkg::ST_C2_LL: begin a_op = $signed(MW'(l[2])); b_op = $signed(MW'(l[2])); end
      default: ;
    endcase
  end

  assign p_d = a_op * b_op;
  assign pu  = $unsigned(p_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= 1'b0;
    end else begin
      pvalid_q <= cmd_i.mul;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    pstep_q <= cmd_i.step;
  end

  // accumulators, fed from the registered product
  logic [SW-1:0]              x2_q;
  logic [DW-1:0]              vl_q;
  logic [lis_pkg::LIM2_W-1:0] lim2_q;

  always_ff @(posedge clk_i) begin
    if (pvalid_q) begin
      unique case (pstep_q)
        lis_pkg::ST_C0_POS: c_q[0] <= CW'(p_q);
        lis_pkg::ST_C0_NEG: c_q[0] <= c_q[0] - CW'(p_q);
        lis_pkg::ST_C1_POS: c_q[1] <= CW'(p_q);
        lis_pkg::ST_C1_NEG: c_q[1] <= c_q[1] - CW'(p_q);
        lis_pkg::ST_C2_POS: c_q[2] <= CW'(p_q);
        lis_pkg::ST_C2_NEG: c_q[2] <= c_q[2] - CW'(p_q);
        lis_pkg::ST_V0:     vl_q <= DW'(pu);
        lis_pkg::ST_V1,
        lis_pkg::ST_V2:     vl_q <= vl_q + DW'(pu);
        lis_pkg::ST_LIM:    lim2_q <= lis_pkg::LIM2_W'(pu);
        lis_pkg::ST_C0_HH:  x2_q <= SW'(pu) << (2 * K);
        lis_pkg::ST_C1_HH,
        lis_pkg::ST_C2_HH:  x2_q <= x2_q + (SW'(pu) << (2 * K));
        lis_pkg::ST_C0_HL,
        lis_pkg::ST_C1_HL,
        lis_pkg::ST_C2_HL:  x2_q <= x2_q + (SW'(pu) << (K + 1));
        lis_pkg::ST_C0_LL,
        lis_pkg::ST_C1_LL,
        lis_pkg::ST_C2_LL:  x2_q <= x2_q + SW'(pu);
        default: ;
      endcase
    end
  end

  // restoring divider, two quotient bits a cycle
  logic [SW-1:0] n_q;
  logic [DW-1:0] rem_q;
  logic [DL-1:0] q_q;
  logic          sat_q;
  logic [DW:0]   r1, r2, r1s, r2s;
  logic          b1, b0;
  logic [DL+1:0] qq;

  always_comb begin
    r1  = {rem_q, n_q[SW-1]};
    b1  = (r1 >= {1'b0, vl_q});
    r1s = b1 ? (r1 - {1'b0, vl_q}) : r1;
    r2  = {r1s[DW-1:0], n_q[SW-2]};
    b0  = (r2 >= {1'b0, vl_q});
    r2s = b0 ? (r2 - {1'b0, vl_q}) : r2;
    qq  = {q_q, b1, b0};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      n_q   <= x2_q;
      rem_q <= '0;
      q_q   <= '0;
      sat_q <= 1'b0;
    end else if (cmd_i.div_step) begin
      n_q   <= n_q << 2;
      rem_q <= r2s[DW-1:0];
      q_q   <= qq[DL-1:0];
      // quotient bits pushed past the top mean the distance overflows
      sat_q <= sat_q | qq[DL+1] | qq[DL];
    end
  end

  // totals and result
  logic [lis_pkg::CNT_W-1:0] cnt_q, cnt_n;
  logic [lis_pkg::ERR_W-1:0] err_q, err_n;
  logic [lis_pkg::ERR_W:0]   err_sum;
  logic [DL-1:0]             dist_val;
  logic                      inl;
  lis_pkg::out_item_t        res_q;

  always_comb begin
    dist_val = sat_q ? lis_pkg::DIST_MAX : q_q;
    // q < limit^2 is the exact threshold test on the unrounded ratio
    inl     = (vl_q != '0) && !sat_q && (q_q < DL'(lim2_q));
    err_sum = {1'b0, err_q} + (lis_pkg::ERR_W + 1)'(dist_val);
    cnt_n   = cnt_q;
    err_n   = err_q;
    if (inl) begin
      if (cnt_q < lis_pkg::COUNT_CAP) begin
        cnt_n = cnt_q + 1'b1;
      end
      err_n = err_sum[lis_pkg::ERR_W] ? lis_pkg::ERR_MAX : err_sum[lis_pkg::ERR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      err_q <= '0;
    end else if (cmd_i.finish) begin
      cnt_q <= last_q ? '0 : cnt_n;
      err_q <= last_q ? '0 : err_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q.is_inlier     <= inl;
      res_q.dist_sq       <= dist_val;
      res_q.inlier_count  <= cnt_n;
      res_q.error_total   <= err_n;
      res_q.line_accepted <= last_q && (cnt_n > min_q);
      res_q.pass_done     <= last_q;
    end
  end

  assign out_item_o = res_q;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line inlier scoring testbench
// Drives hit points and register writes into the scoring block, predicts
// distance, inlier flag and pass totals in parallel, and checks each result
// in order against the predicted one.
// ----------------------------------------------------------------------------
module tb;
  import lis_pkg::*;

  class score_board;
    out_item_t pending[$];
    int errors;
    logic signed [15:0] pts[6];
    logic [11:0] lim;
    logic [12:0] min_in;
    logic [12:0] cnt;
    logic [35:0] err_sum;

    function new();
      errors = 0;
      foreach (pts[k]) pts[k] = '0;
      lim = LIMIT_RESET;
      min_in = MIN_RESET;
      cnt = '0;
      err_sum = '0;
    endfunction

    function void write_reg(logic [3:0] idx, logic [15:0] val);
      if (idx <= REG_SECOND_Z) pts[idx] = val;
      else if (idx == REG_INLIER_LIMIT) lim = val[11:0];
      else if (idx == REG_MIN_INLIERS) min_in = val[12:0];
    endfunction

    // one accepted hit point: predict its result
    function void note_point(in_item_t p);
      logic signed [69:0] dir[3], w[3];
      logic signed [69:0] c[3];
      logic [127:0] cr2, vl2, thr, q;
      out_item_t r;
      dir[0] = pts[3] - pts[0];
      dir[1] = pts[4] - pts[1];
      dir[2] = pts[5] - pts[2];
      w[0] = pts[0] - p.pos_x;
      w[1] = pts[1] - p.pos_y;
      w[2] = pts[2] - p.pos_z;
      c[0] = dir[1] * w[2] - dir[2] * w[1];
      c[1] = dir[2] * w[0] - dir[0] * w[2];
      c[2] = dir[0] * w[1] - dir[1] * w[0];
      cr2 = 128'(c[0] * c[0]) + 128'(c[1] * c[1]) + 128'(c[2] * c[2]);
      vl2 = 128'(dir[0] * dir[0]) + 128'(dir[1] * dir[1]) + 128'(dir[2] * dir[2]);
      r = '0;
      r.dist_sq = DIST_MAX;
      if (vl2 != 0) begin
        q = cr2 / vl2;
        if (q <= 128'(DIST_MAX)) r.dist_sq = q[33:0];
        thr = 128'(lim) * 128'(lim) * vl2;
        r.is_inlier = cr2 < thr;
      end
      if (r.is_inlier) begin
        if (cnt < COUNT_CAP) cnt++;
        if (ERR_MAX - err_sum < 36'(r.dist_sq)) err_sum = ERR_MAX;
        else err_sum = err_sum + 36'(r.dist_sq);
      end
      r.inlier_count = cnt;
      r.error_total = err_sum;
      r.pass_done = p.last_point;
      r.line_accepted = p.last_point && (cnt > min_in);
      if (p.last_point) begin
        cnt = '0;
        err_sum = '0;
      end
      pending = {pending, r};
    endfunction

    task check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        report_err("result with nothing pending");
        return;
      end
      e = pending.pop_front();
      if (got.is_inlier != e.is_inlier) report_err("is_inlier");
      if (got.dist_sq != e.dist_sq) report_err("dist_sq");
      if (got.inlier_count != e.inlier_count) report_err("inlier_count");
      if (got.error_total != e.error_total) report_err("error_total");
      if (got.line_accepted != e.line_accepted) report_err("line_accepted");
      if (got.pass_done != e.pass_done) report_err("pass_done");
    endtask

    task report_err(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  always #4 clk_i = ~clk_i;

  lis_chan_if #(cfg_req_t)  cfg_ch();
  lis_chan_if #(in_item_t)  in_ch();
  lis_chan_if #(out_item_t) out_ch();

  ransac_line_inlier_scoring dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_i(cfg_ch.sink), .in_i(in_ch.sink),
    .out_o(out_ch.source)
  );

  score_board sb = new();
  bit quiet = 0;        // no idling in the final stretch
  int hold_off = 0;     // long receiver stall request
  int rx_idle = 0;      // remaining cycles of a short receiver idle burst
  int cycles = 0;

  initial begin
    cfg_ch.valid = 0; cfg_ch.data = '0;
    in_ch.valid = 0; in_ch.data = '0;
    out_ch.ready = 0;
  end

  // result side
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ch.ready <= 0;
      end else if (rx_idle > 0) begin
        rx_idle <= rx_idle - 1;
        out_ch.ready <= 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rx_idle <= $urandom_range(0, 7);
        out_ch.ready <= 0;
      end else out_ch.ready <= 1;
    end
  end

  always @(posedge clk_i)
    if (cycles > 400000) begin
      $display("Verification failed");
      $finish;
    end

  task automatic wr_reg(logic [3:0] idx, logic [15:0] val);
    cfg_ch.valid <= 1;
    cfg_ch.data <= '{index: idx, value: val};
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.write_reg(idx, val);
    cfg_ch.valid <= 0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic send_point(logic [15:0] x, y, z, logic lst);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1;
    in_ch.data <= '{pos_x: x, pos_y: y, pos_z: z, last_point: lst};
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_point(in_ch.data);
  endtask

  task automatic stop_sending();
    in_ch.valid <= 0;
    @(posedge clk_i);
  endtask

  // point near the line: anchor + t*dir/16 + small noise
  task automatic near_point(int t, int spread, logic lst);
    int v[3];
    for (int k = 0; k < 3; k++)
      v[k] = sb.pts[k] + t * (sb.pts[k+3] - sb.pts[k]) / 16
             + $signed($urandom_range(0, 2 * spread)) - spread;
    send_point(16'(v[0]), 16'(v[1]), 16'(v[2]), lst);
  endtask

  task automatic set_line(logic [15:0] a0, a1, a2, b0, b1, b2);
    wr_reg(REG_ANCHOR_X, a0); wr_reg(REG_ANCHOR_Y, a1); wr_reg(REG_ANCHOR_Z, a2);
    wr_reg(REG_SECOND_X, b0); wr_reg(REG_SECOND_Y, b1); wr_reg(REG_SECOND_Z, b2);
  endtask

  initial begin
    int n, len;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // reset line is degenerate: never an inlier, distance saturates
    send_point(16'h0000, 16'h0000, 16'h0000, 0);
    send_point(16'h7fff, 16'h8000, 16'h0001, 1);
    stop_sending();
    drain();

    // extreme line, extreme points, distance overflow
    set_line(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
    wr_reg(REG_INLIER_LIMIT, 16'h0fff);
    wr_reg(REG_MIN_INLIERS, 16'd0);
    send_point(16'h8000, 16'h7fff, 16'h8000, 0);
    send_point(16'h7fff, 16'h8000, 16'h8000, 0);
    send_point(16'h0000, 16'h0000, 16'h0000, 0);
    send_point(16'hffff, 16'hffff, 16'hffff, 1);
    send_point(16'h8000, 16'h8000, 16'h7fff, 1);
    stop_sending();
    drain();
    set_line(16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000);
    wr_reg(REG_INLIER_LIMIT, 16'h0000);
    wr_reg(REG_MIN_INLIERS, 16'h1000);
    send_point(16'h0005, 16'h0000, 16'h0000, 0);
    send_point(16'h7fff, 16'h7fff, 16'h7fff, 1);
    stop_sending();
    drain();
    wr_reg(REG_INLIER_LIMIT, 16'hffff);   // upper bits dropped
    wr_reg(REG_MIN_INLIERS, 16'd1);
    wr_reg(4'd9, 16'h1234);               // unknown index ignored
    send_point(16'h0003, 16'h0100, 16'h0000, 0);
    send_point(16'h0003, 16'h0000, 16'h0000, 0);
    send_point(16'h8000, 16'h0000, 16'h0000, 1);
    stop_sending();

    // long receiver stall while points keep coming
    hold_off = 400;
    for (int i = 0; i < 6; i++) send_point(16'($urandom), 16'($urandom), 16'($urandom), 0);
    stop_sending();
    drain();

    n = 0;
    while (n < 1300) begin
      if (n > 1150) quiet = 1;
      case ($urandom_range(0, 5))
        0: set_line(16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom));
        1: set_line(16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)), 16'd0,
                    16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000)),
                    16'($urandom_range(0, 4000)));
        default: ;
      endcase
      wr_reg(REG_INLIER_LIMIT, 16'($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 400)));
      wr_reg(REG_MIN_INLIERS, 16'($urandom_range(0, 40)));
      len = $urandom_range(1, 60);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 4) == 0)
          send_point(16'($urandom), 16'($urandom), 16'($urandom), i == len - 1);
        else near_point($urandom_range(0, 64) - 32, $urandom_range(0, 300), i == len - 1);
        n++;
      end
      stop_sending();
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
